// File: src/ppd_pkg.sv
`timescale 1ns / 1ps

package ppd_pkg;

    localparam int CLIP_W     = 15;
    localparam int SQ_W       = 30;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_WIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEAT_WIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRACT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PEAKS = 2'd3;

    localparam logic [7:0]  PEAK_WIN_RST  = 8'd8;
    localparam logic [7:0]  BEAT_WIN_RST  = 8'd43;
    localparam logic [11:0] REFRACT_RST   = 12'd19;
    localparam logic [11:0] MAX_PEAKS_RST = 12'd409;

    localparam logic KIND_PEAK    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } in_word_t;

    typedef struct packed {
        logic               kind;
        logic [11:0]        peak_index;
        logic signed [15:0] peak_value;
        logic [11:0]        peak_count;
        logic               done_res;
    } out_word_t;

    // classified sample handed from front end to back end
    typedef struct packed {
        logic signed [15:0]  sample;
        logic [CLIP_W-1:0]   clip;
        logic                last;
        logic                drop;
        logic                first;
    } item_t;

endpackage

// File: src/ppd_front.sv
`timescale 1ns / 1ps

module ppd_front #(
    parameter int MAX_WINDOW  = 128,
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ppd_pkg::in_word_t                   s_data,
    input  logic                                q_full,
    output logic                                q_push,
    output ppd_pkg::item_t                      q_item,
    output logic [$clog2(MAX_SAMPLES)-1:0]      q_idx,
    output logic [$clog2(MAX_WINDOW)-1:0]       q_wp
);

    localparam int IW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int AW = $clog2(MAX_WINDOW);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic          take;
    logic          drop;
    logic          positive;

    assign s_ready  = !q_full;
    assign take     = s_valid && s_ready;
    assign drop     = (cnt_reg == CW'(MAX_SAMPLES));
    assign positive = !s_data.sample[15] && (s_data.sample != '0);

    assign q_push       = take;
    assign q_item.sample = s_data.sample;
    assign q_item.clip   = positive ? s_data.sample[ppd_pkg::CLIP_W-1:0] : '0;
    assign q_item.last   = s_data.last;
    assign q_item.drop   = drop;
    assign q_item.first  = (cnt_reg == '0);
    assign q_idx         = cnt_reg[IW-1:0];
    assign q_wp          = wp_reg;

    always_comb begin
        cnt_next = cnt_reg;
        wp_next  = wp_reg;
        if (take) begin
            if (s_data.last) begin
                cnt_next = '0;
                wp_next  = '0;
            end else if (!drop) begin
                cnt_next = cnt_reg + CW'(1);
                wp_next  = (wp_reg == AW'(MAX_WINDOW - 1)) ? '0 : wp_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            wp_reg  <= '0;
        end else begin
            cnt_reg <= cnt_next;
            wp_reg  <= wp_next;
        end
    end

endmodule

// File: src/ppd_fifo.sv
`timescale 1ns / 1ps

module ppd_fifo #(
    parameter int W = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         pop_valid,
    output logic [W-1:0] pop_data
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    logic [W-1:0]  data_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == NW'(DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_data  = data_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + PW'(1);
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + NW'(1);
            2'b01:   cnt_next = cnt_reg - NW'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (full && !pop) |-> !push)
        else $error("ppd_fifo: push into full queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> pop_valid)
        else $error("ppd_fifo: pop from empty queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + NW'(1)))
        else $error("ppd_fifo: count lost a word");

endmodule

// File: src/ppd_back.sv
`timescale 1ns / 1ps

module ppd_back #(
    parameter int MAX_WINDOW  = 128,
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wen,
    input  logic [ppd_pkg::CFG_IDX_W-1:0]         cfg_idx,
    input  logic [ppd_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                  q_valid,
    output logic                                  q_pop,
    input  ppd_pkg::item_t                        q_item,
    input  logic [$clog2(MAX_SAMPLES)-1:0]        q_idx,
    input  logic [$clog2(MAX_WINDOW)-1:0]         q_wp,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output ppd_pkg::out_word_t                    m_data
);

    localparam int IW  = $clog2(MAX_SAMPLES);
    localparam int AW  = $clog2(MAX_WINDOW);
    localparam int WLW = $clog2(MAX_WINDOW + 1);
    localparam int CLW = ppd_pkg::CLIP_W;
    localparam int SQW = ppd_pkg::SQ_W;
    localparam int SW  = SQW + WLW;
    localparam int XW  = SW + WLW;
    localparam int EW  = IW + WLW;
    localparam int RW  = IW + 12;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SQ    = 9'b000000010,
        ST_ACC   = 9'b000000100,
        ST_SUBP  = 9'b000001000,
        ST_SUBB  = 9'b000010000,
        ST_CROSS = 9'b000100000,
        ST_JUDGE = 9'b001000000,
        ST_PEAK  = 9'b010000000,
        ST_SUM   = 9'b100000000
    } state_t;

    function automatic logic [WLW-1:0] clamp_w(input logic [7:0] w);
        logic [WLW+7:0] wx;
        wx = {{WLW{1'b0}}, w};
        if (w == '0) begin
            return WLW'(1);
        end else if (wx > (WLW+8)'(MAX_WINDOW)) begin
            return WLW'(MAX_WINDOW);
        end else begin
            return wx[WLW-1:0];
        end
    endfunction

    // (wp - w) modulo the history depth, w never above the depth
    function automatic logic [AW-1:0] back_addr(input logic [AW-1:0] wp,
                                                input logic [WLW-1:0] w);
        logic [WLW:0] t;
        t = (WLW+1)'(wp) + (WLW+1)'(MAX_WINDOW) - (WLW+1)'(w);
        if (t >= (WLW+1)'(MAX_WINDOW)) begin
            t = t - (WLW+1)'(MAX_WINDOW);
        end
        return t[AW-1:0];
    endfunction

    state_t state_reg, state_next;

    logic [7:0]  pw_cfg_reg, pw_cfg_next;
    logic [7:0]  bw_cfg_reg, bw_cfg_next;
    logic [11:0] refr_reg, refr_next;
    logic [11:0] maxp_reg, maxp_next;

    logic [WLW-1:0] pw_reg, pw_next;
    logic [WLW-1:0] bw_reg, bw_next;

    ppd_pkg::item_t e_item_reg, e_item_next;
    logic [IW-1:0]  e_idx_reg, e_idx_next;
    logic [AW-1:0]  e_wp_reg, e_wp_next;

    logic [SW-1:0]  psum_reg, psum_next;
    logic [SW-1:0]  bsum_reg, bsum_next;
    logic [SQW-1:0] sq_reg, sq_next;
    logic [XW-1:0]  xp_reg, xp_next;
    logic [XW-1:0]  xb_reg, xb_next;

    logic               in_block_reg, in_block_next;
    logic [WLW-1:0]     blen_reg, blen_next;
    logic signed [15:0] best_value_reg, best_value_next;
    logic [IW-1:0]      best_idx_reg, best_idx_next;
    logic               have_peak_reg, have_peak_next;
    logic [IW-1:0]      last_idx_reg, last_idx_next;
    logic [11:0]        acc_reg, acc_next;

    logic               m_valid_reg, m_valid_next;
    ppd_pkg::out_word_t m_data_reg, m_data_next;

    logic [CLW-1:0] hist_mem [MAX_WINDOW];
    logic [CLW-1:0] rd_reg;
    logic [AW-1:0]  rd_addr;
    logic           mem_rd;
    logic           mem_we;

    logic [CLW-1:0] sq_a;
    logic [SQW-1:0] sq_prod;

    logic [EW-1:0]  idx_x, pw_x, bw_x, cnt1;
    logic           past_p, past_b;
    logic [WLW-1:0] dp, db;

    logic               out_free;
    logic               above, opening, extend_blk, better, in_blk_upd, close_now;
    logic [WLW-1:0]     blen_upd;
    logic signed [15:0] best_upd;
    logic [IW-1:0]      idx_upd, idx_gap;
    logic               far, peak_ok;
    logic [RW-1:0]      idx_wide;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign sq_a    = (state_reg == ST_SQ) ? e_item_reg.clip : rd_reg;
    assign sq_prod = SQW'(sq_a) * SQW'(sq_a);
    assign rd_addr = (state_reg == ST_ACC) ? back_addr(e_wp_reg, bw_reg)
                                           : back_addr(e_wp_reg, pw_reg);

    assign idx_x  = EW'(e_idx_reg);
    assign pw_x   = EW'(pw_reg);
    assign bw_x   = EW'(bw_reg);
    assign cnt1   = idx_x + EW'(1);
    assign past_p = (idx_x >= pw_x);
    assign past_b = (idx_x >= bw_x);
    assign dp     = (cnt1 < pw_x) ? cnt1[WLW-1:0] : pw_reg;
    assign db     = (cnt1 < bw_x) ? cnt1[WLW-1:0] : bw_reg;

    // block tracking for the word in the judge step
    assign above      = !e_item_reg.drop && (xp_reg > xb_reg);
    assign opening    = above && !in_block_reg;
    assign extend_blk = above && in_block_reg;
    assign better     = extend_blk && (e_item_reg.sample > best_value_reg);
    assign in_blk_upd = in_block_reg || above;
    assign blen_upd   = opening ? WLW'(1)
                      : (extend_blk && (blen_reg != WLW'(MAX_WINDOW))) ? blen_reg + WLW'(1)
                      : blen_reg;
    assign best_upd   = (opening || better) ? e_item_reg.sample : best_value_reg;
    assign idx_upd    = (opening || better) ? e_idx_reg : best_idx_reg;
    assign close_now  = in_blk_upd && (e_item_reg.last || (!e_item_reg.drop && !above));
    assign idx_gap    = idx_upd - last_idx_reg;
    assign far        = !have_peak_reg || (RW'(idx_gap) >= RW'(refr_reg));
    assign peak_ok    = close_now && (blen_upd >= pw_reg) && far && (acc_reg < maxp_reg);
    assign idx_wide   = {12'd0, best_idx_reg};

    always_comb begin
        state_next      = state_reg;
        pw_cfg_next     = pw_cfg_reg;
        bw_cfg_next     = bw_cfg_reg;
        refr_next       = refr_reg;
        maxp_next       = maxp_reg;
        pw_next         = pw_reg;
        bw_next         = bw_reg;
        e_item_next     = e_item_reg;
        e_idx_next      = e_idx_reg;
        e_wp_next       = e_wp_reg;
        psum_next       = psum_reg;
        bsum_next       = bsum_reg;
        sq_next         = sq_reg;
        xp_next         = xp_reg;
        xb_next         = xb_reg;
        in_block_next   = in_block_reg;
        blen_next       = blen_reg;
        best_value_next = best_value_reg;
        best_idx_next   = best_idx_reg;
        have_peak_next  = have_peak_reg;
        last_idx_next   = last_idx_reg;
        acc_next        = acc_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        q_pop           = 1'b0;
        mem_rd          = 1'b0;
        mem_we          = 1'b0;

        if (cfg_wen) begin
            case (cfg_idx)
                ppd_pkg::CFG_PEAK_WIN:  pw_cfg_next = cfg_wdata[7:0];
                ppd_pkg::CFG_BEAT_WIN:  bw_cfg_next = cfg_wdata[7:0];
                ppd_pkg::CFG_REFRACT:   refr_next   = cfg_wdata;
                ppd_pkg::CFG_MAX_PEAKS: maxp_next   = cfg_wdata;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop       = 1'b1;
                    e_item_next = q_item;
                    e_idx_next  = q_idx;
                    e_wp_next   = q_wp;
                    if (q_item.first) begin
                        pw_next = clamp_w(pw_cfg_reg);
                        bw_next = clamp_w(bw_cfg_reg);
                    end
                    state_next = q_item.drop ? ST_JUDGE : ST_SQ;
                end
            end
            ST_SQ: begin
                sq_next    = sq_prod;
                mem_rd     = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                psum_next  = psum_reg + SW'(sq_reg);
                bsum_next  = bsum_reg + SW'(sq_reg);
                sq_next    = sq_prod;
                mem_rd     = 1'b1;
                state_next = ST_SUBP;
            end
            ST_SUBP: begin
                if (past_p) begin
                    psum_next = psum_reg - SW'(sq_reg);
                end
                sq_next    = sq_prod;
                mem_we     = 1'b1;
                state_next = ST_SUBB;
            end
            ST_SUBB: begin
                if (past_b) begin
                    bsum_next = bsum_reg - SW'(sq_reg);
                end
                state_next = ST_CROSS;
            end
            ST_CROSS: begin
                xp_next    = XW'(psum_reg) * XW'(db);
                xb_next    = XW'(bsum_reg) * XW'(dp);
                state_next = ST_JUDGE;
            end
            ST_JUDGE: begin
                in_block_next   = in_blk_upd && !close_now;
                blen_next       = close_now ? '0 : blen_upd;
                best_value_next = best_upd;
                best_idx_next   = idx_upd;
                if (peak_ok) begin
                    acc_next       = acc_reg + 12'd1;
                    have_peak_next = 1'b1;
                    last_idx_next  = idx_upd;
                    state_next     = ST_PEAK;
                end else if (e_item_reg.last) begin
                    state_next = ST_SUM;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PEAK: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.kind       = ppd_pkg::KIND_PEAK;
                    m_data_next.peak_index = idx_wide[11:0];
                    m_data_next.peak_value = best_value_reg;
                    m_data_next.peak_count = acc_reg;
                    m_data_next.done_res   = !e_item_reg.last;
                    state_next             = e_item_reg.last ? ST_SUM : ST_IDLE;
                end
            end
            ST_SUM: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.kind       = ppd_pkg::KIND_SUMMARY;
                    m_data_next.peak_index = '0;
                    m_data_next.peak_value = '0;
                    m_data_next.peak_count = acc_reg;
                    m_data_next.done_res   = 1'b1;
                    psum_next              = '0;
                    bsum_next              = '0;
                    in_block_next          = 1'b0;
                    blen_next              = '0;
                    have_peak_next         = 1'b0;
                    last_idx_next          = '0;
                    acc_next               = '0;
                    state_next             = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pw_cfg_reg    <= ppd_pkg::PEAK_WIN_RST;
            bw_cfg_reg    <= ppd_pkg::BEAT_WIN_RST;
            refr_reg      <= ppd_pkg::REFRACT_RST;
            maxp_reg      <= ppd_pkg::MAX_PEAKS_RST;
            pw_reg        <= clamp_w(ppd_pkg::PEAK_WIN_RST);
            bw_reg        <= clamp_w(ppd_pkg::BEAT_WIN_RST);
            psum_reg      <= '0;
            bsum_reg      <= '0;
            in_block_reg  <= 1'b0;
            blen_reg      <= '0;
            have_peak_reg <= 1'b0;
            last_idx_reg  <= '0;
            acc_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pw_cfg_reg    <= pw_cfg_next;
            bw_cfg_reg    <= bw_cfg_next;
            refr_reg      <= refr_next;
            maxp_reg      <= maxp_next;
            pw_reg        <= pw_next;
            bw_reg        <= bw_next;
            psum_reg      <= psum_next;
            bsum_reg      <= bsum_next;
            in_block_reg  <= in_block_next;
            blen_reg      <= blen_next;
            have_peak_reg <= have_peak_next;
            last_idx_reg  <= last_idx_next;
            acc_reg       <= acc_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        e_item_reg     <= e_item_next;
        e_idx_reg      <= e_idx_next;
        e_wp_reg       <= e_wp_next;
        sq_reg         <= sq_next;
        xp_reg         <= xp_next;
        xb_reg         <= xb_next;
        best_value_reg <= best_value_next;
        best_idx_reg   <= best_idx_next;
        m_data_reg     <= m_data_next;
    end

    // clipped-sample history
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hist_mem[e_wp_reg] <= e_item_reg.clip;
        end
        if (mem_rd) begin
            rd_reg <= hist_mem[rd_addr];
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        have_peak_reg == (acc_reg != '0))
        else $error("ppd_back: peak flag out of step with count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        in_block_reg |-> (blen_reg != '0))
        else $error("ppd_back: open block with zero length");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PEAK) |-> (have_peak_reg && !in_block_reg))
        else $error("ppd_back: peak emitted without a closed block");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUM && out_free) |=>
            (acc_reg == '0 && !in_block_reg && psum_reg == '0 && bsum_reg == '0))
        else $error("ppd_back: window state not cleared after summary");

endmodule

// File: src/pulse_peak_detector.sv
`timescale 1ns / 1ps

// channel  dir  handshake          payload
// s_       in   s_valid / s_ready  s_data    (ppd_pkg::in_word_t)
// m_       out  m_valid / m_ready  m_data    (ppd_pkg::out_word_t)
// cfg_     in   cfg_wen            cfg_idx, cfg_wdata
//
// Back end: idle, square, accumulate, subtract peak, subtract beat, cross products, judge
// per sample word (shared squarer over three squares, one history read per window),
// then a result step per result; a word past MAX_SAMPLES skips from idle to judge.
// Reset is synchronous; no clearing pass, a history read is only used where written.
// A 2-word queue sits between front and back; s_ready drops only when it is full.
// m_ready low holds the back end in its result step; output is registered.

module pulse_peak_detector #(
    parameter int MAX_WINDOW  = 128,
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  ppd_pkg::in_word_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output ppd_pkg::out_word_t             m_data,
    input  logic                           cfg_wen,
    input  logic [ppd_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [ppd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int IW = $clog2(MAX_SAMPLES);
    localparam int AW = $clog2(MAX_WINDOW);
    localparam int QW = $bits(ppd_pkg::item_t) + IW + AW;

    logic           q_push, q_full, q_pop, q_valid;
    ppd_pkg::item_t f_item, b_item;
    logic [IW-1:0]  f_idx, b_idx;
    logic [AW-1:0]  f_wp, b_wp;
    logic [QW-1:0]  q_in, q_out;

    assign q_in                   = {f_item, f_idx, f_wp};
    assign {b_item, b_idx, b_wp}  = q_out;

    ppd_front #(
        .MAX_WINDOW  (MAX_WINDOW),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_item  (f_item),
        .q_idx   (f_idx),
        .q_wp    (f_wp)
    );

    ppd_fifo #(
        .W (QW)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_out)
    );

    ppd_back #(
        .MAX_WINDOW  (MAX_WINDOW),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (b_item),
        .q_idx     (b_idx),
        .q_wp      (b_wp),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// File: test/pulse_peak_detector_tb.sv
`timescale 1ns / 1ps

module pulse_peak_detector_tb;

    localparam int MAX_WIN    = 128;
    localparam int MAX_SAMP   = 4096;
    localparam int QUIET_MAX  = 5000;
    localparam int DRAIN_WAIT = 64;
    localparam int HOLD_LEN   = 400;
    localparam int RAND_ITEMS = 1700;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    ppd_pkg::in_word_t              s_data    = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    ppd_pkg::out_word_t             m_data;
    logic                           cfg_wen   = 1'b0;
    logic [ppd_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [ppd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    pulse_peak_detector #(
        .MAX_WINDOW (MAX_WIN),
        .MAX_SAMPLES(MAX_SAMP)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_wen  (cfg_wen),
        .cfg_idx  (cfg_idx),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // register copies
    logic [7:0]  reg_peak_win  = ppd_pkg::PEAK_WIN_RST;
    logic [7:0]  reg_beat_win  = ppd_pkg::BEAT_WIN_RST;
    logic [11:0] reg_refract   = ppd_pkg::REFRACT_RST;
    logic [11:0] reg_max_peaks = ppd_pkg::MAX_PEAKS_RST;

    // detector state
    logic [14:0]     hist_sq [MAX_WIN];
    longint unsigned sum_short, sum_long;
    int unsigned     idx_n, blk_len, best_idx, prev_peak_idx, n_peaks;
    int unsigned     win_short = 8, win_long = 43;
    int              best_val;
    bit              blk_open, seen_peak;

    ppd_pkg::in_word_t  sample_queue [$];
    ppd_pkg::out_word_t due_words [$];
    int        pushed_cnt   = 0;
    int        sent_cnt     = 0;
    int        n_errors     = 0;
    int        idle_pct     = 0;
    int        tx_gap       = 0;
    int        rx_gap       = 0;
    int        quiet_cycles = 0;
    bit        hold_go      = 1'b0;
    logic      rx_hold      = 1'b0;

    function automatic int unsigned clamp_win(int unsigned w);
        if (w < 1) return 1;
        if (w > MAX_WIN) return MAX_WIN;
        return w;
    endfunction

    function automatic void clear_window();
        foreach (hist_sq[k]) hist_sq[k] = '0;
        sum_short     = 0;
        sum_long      = 0;
        idx_n         = 0;
        blk_open      = 1'b0;
        blk_len       = 0;
        best_val      = 0;
        best_idx      = 0;
        seen_peak     = 1'b0;
        prev_peak_idx = 0;
        n_peaks       = 0;
    endfunction

    function automatic void put_word(logic kind, int unsigned idx, int val,
                                     int unsigned cnt, logic done);
        ppd_pkg::out_word_t w;
        w.kind       = kind;
        w.peak_index = idx[11:0];
        w.peak_value = val[15:0];
        w.peak_count = cnt[11:0];
        w.done_res   = done;
        due_words.push_back(w);
    endfunction

    function automatic bit judge_block();
        bit ok = 1'b0;
        blk_open = 1'b0;
        if (blk_len >= win_short) begin
            if ((!seen_peak || best_idx - prev_peak_idx >= reg_refract) &&
                n_peaks < reg_max_peaks) begin
                n_peaks       = (n_peaks + 1) & 32'hFFF;
                seen_peak     = 1'b1;
                prev_peak_idx = best_idx;
                ok            = 1'b1;
            end
        end
        blk_len = 0;
        return ok;
    endfunction

    task automatic track_sample(ppd_pkg::in_word_t w);
        int              v;
        int unsigned     i, c, cnt, dp, db;
        longint unsigned sq, o;
        bit              above;
        v = $signed(w.sample);
        if (idx_n < MAX_SAMP) begin
            i  = idx_n;
            c  = (v > 0) ? v : 0;
            sq = longint'(c) * longint'(c);
            if (i == 0) begin
                win_short = clamp_win(reg_peak_win);
                win_long  = clamp_win(reg_beat_win);
            end
            sum_short += sq;
            sum_long  += sq;
            if (i >= win_short) begin
                o = hist_sq[(i - win_short) % MAX_WIN];
                sum_short -= o * o;
            end
            if (i >= win_long) begin
                o = hist_sq[(i - win_long) % MAX_WIN];
                sum_long -= o * o;
            end
            hist_sq[i % MAX_WIN] = c[14:0];
            cnt   = i + 1;
            dp    = (cnt < win_short) ? cnt : win_short;
            db    = (cnt < win_long) ? cnt : win_long;
            above = sum_short * db > sum_long * dp;
            if (above) begin
                if (!blk_open) begin
                    blk_open = 1'b1;
                    blk_len  = 1;
                    best_val = v;
                    best_idx = i;
                end else begin
                    blk_len++;
                    if (v > best_val) begin
                        best_val = v;
                        best_idx = i;
                    end
                end
            end else if (blk_open) begin
                if (judge_block())
                    put_word(ppd_pkg::KIND_PEAK, best_idx, best_val, n_peaks, !w.last);
            end
            idx_n = i + 1;
        end
        if (w.last) begin
            if (blk_open && judge_block())
                put_word(ppd_pkg::KIND_PEAK, best_idx, best_val, n_peaks, 1'b0);
            put_word(ppd_pkg::KIND_SUMMARY, 0, 0, n_peaks, 1'b1);
            clear_window();
        end
    endtask

    // sender
    always @(posedge aclk) begin
        if (s_valid && s_ready) begin
            track_sample(s_data);
            sent_cnt++;
        end
        if (!s_valid || s_ready) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_valid <= 1'b0;
            end else if (aresetn && sample_queue.size() != 0) begin
                if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                    tx_gap = $urandom_range(0, 14);
                    s_valid <= 1'b0;
                end else begin
                    s_data  <= sample_queue.pop_front();
                    s_valid <= 1'b1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        ppd_pkg::out_word_t want;
        if (m_valid && m_ready) begin
            if (due_words.size() == 0) begin
                if (n_errors < 10)
                    $display("unexpected word: kind %0d index %0d value %0d count %0d done %0d",
                             m_data.kind, m_data.peak_index, $signed(m_data.peak_value),
                             m_data.peak_count, m_data.done_res);
                n_errors++;
            end else begin
                want = due_words.pop_front();
                if (m_data.kind !== want.kind || m_data.peak_index !== want.peak_index ||
                    m_data.peak_value !== want.peak_value ||
                    m_data.peak_count !== want.peak_count ||
                    m_data.done_res !== want.done_res) begin
                    if (n_errors < 10) begin
                        $display("mismatch exp: kind %0d index %0d value %0d count %0d done %0d",
                                 want.kind, want.peak_index, $signed(want.peak_value),
                                 want.peak_count, want.done_res);
                        $display("         got: kind %0d index %0d value %0d count %0d done %0d",
                                 m_data.kind, m_data.peak_index, $signed(m_data.peak_value),
                                 m_data.peak_count, m_data.done_res);
                    end
                    n_errors++;
                end
            end
        end
        if (rx_gap > 0)
            rx_gap--;
        else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            rx_gap = $urandom_range(1, 15);
        m_ready <= aresetn && !rx_hold && rx_gap == 0;
    end

    // long output stall so the input queue backs up
    initial begin
        wait (hold_go);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_LEN) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_MAX) begin
            $display("pulse_peak_detector_tb: errors");
            $finish;
        end
    end

    task automatic push_word(logic [15:0] s, logic l);
        ppd_pkg::in_word_t w;
        w.sample = s;
        w.last   = l;
        sample_queue.push_back(w);
        pushed_cnt++;
    endtask

    task automatic settle();
        while (sent_cnt != pushed_cnt || due_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(logic [ppd_pkg::CFG_IDX_W-1:0] idx,
                             logic [ppd_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        case (idx)
            ppd_pkg::CFG_PEAK_WIN:  reg_peak_win  = val[7:0];
            ppd_pkg::CFG_BEAT_WIN:  reg_beat_win  = val[7:0];
            ppd_pkg::CFG_REFRACT:   reg_refract   = val;
            ppd_pkg::CFG_MAX_PEAKS: reg_max_peaks = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wen <= 1'b0;
    endtask

    task automatic random_config();
        int unsigned pw, bw, rf, mp;
        case ($urandom_range(0, 9))
            0:       pw = 0;
            1:       pw = MAX_WIN;
            2:       pw = $urandom_range(0, 4095);
            default: pw = $urandom_range(1, 16);
        endcase
        case ($urandom_range(0, 9))
            0:       bw = 1;
            1:       bw = MAX_WIN;
            2:       bw = $urandom_range(0, 4095);
            default: bw = $urandom_range(8, 100);
        endcase
        case ($urandom_range(0, 9))
            0:       rf = 0;
            1:       rf = 4095;
            2:       rf = $urandom_range(0, 4095);
            default: rf = $urandom_range(0, 40);
        endcase
        case ($urandom_range(0, 9))
            0:       mp = 0;
            1:       mp = 1;
            2:       mp = 4095;
            3:       mp = $urandom_range(0, 4095);
            default: mp = $urandom_range(2, 40);
        endcase
        write_reg(ppd_pkg::CFG_PEAK_WIN, pw[11:0]);
        write_reg(ppd_pkg::CFG_BEAT_WIN, bw[11:0]);
        write_reg(ppd_pkg::CFG_REFRACT, rf[11:0]);
        write_reg(ppd_pkg::CFG_MAX_PEAKS, mp[11:0]);
    endtask

    // pulse train with noisy undershoot; exact triangles give ties at the top
    task automatic add_window(int unsigned n, bit close, bit noisy);
        int unsigned period, width, ph, pos, tri_h;
        int          amp, cap, s;
        bit          flat;
        period = $urandom_range(6, 70);
        width  = $urandom_range(2, period);
        amp    = $urandom_range(100, 32767);
        cap    = amp * 2 / 3;
        flat   = $urandom_range(0, 2) == 0;
        ph     = $urandom_range(0, period - 1);
        for (int unsigned k = 0; k < n; k++) begin
            pos = (k + ph) % period;
            if (noisy || $urandom_range(0, 63) == 0) begin
                s = int'($urandom_range(0, 65535)) - 32768;
            end else if (pos < width) begin
                tri_h = (pos < width / 2) ? pos + 1 : width - pos;
                s = amp * int'(tri_h) / int'((width + 1) / 2);
                if (flat && s > cap) s = cap;
            end else begin
                s = -int'($urandom_range(0, amp / 4)) + int'($urandom_range(0, 64)) - 32;
                if (s < -32768) s = -32768;
            end
            push_word(s[15:0], close && k == n - 1);
        end
    endtask

    initial begin
        int          dir_a [14] = '{0, 0, 0, -32768, 32767, 32767, -1, 1, 0, 0, 0,
                                    20000, 30000, 32767};
        int          phase, n_win, len;
        bit          close;
        clear_window();
        phase = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // one-word window at full scale
        push_word(16'sh7FFF, 1'b1);
        settle();

        // zero peak length, tiny beat window, no refractory, full cap
        write_reg(ppd_pkg::CFG_PEAK_WIN, 12'd0);
        write_reg(ppd_pkg::CFG_BEAT_WIN, 12'd4);
        write_reg(ppd_pkg::CFG_REFRACT, 12'd0);
        write_reg(ppd_pkg::CFG_MAX_PEAKS, 12'd4095);
        foreach (dir_a[k]) push_word(dir_a[k][15:0], k == 13);
        settle();

        // lengths rewritten mid-window, oversized values
        push_word(16'sd0, 1'b0);
        push_word(16'sd15000, 1'b0);
        settle();
        write_reg(ppd_pkg::CFG_PEAK_WIN, 12'h0C8);
        write_reg(ppd_pkg::CFG_BEAT_WIN, 12'hFFF);
        push_word(16'sd30000, 1'b0);
        push_word(16'sd100, 1'b1);
        push_word(16'sd9000, 1'b1);
        settle();

        while (pushed_cnt < RAND_ITEMS) begin
            random_config();
            if (pushed_cnt > RAND_ITEMS - 250) begin
                idle_pct = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 8;
                    default: idle_pct = 25;
                endcase
            end
            if (phase == 1) begin
                idle_pct = 0;
                hold_go  = 1'b1;
                repeat (60) add_window($urandom_range(1, 4), 1'b1, 1'b0);
            end else begin
                n_win = $urandom_range(1, 4);
                for (int w = 0; w < n_win; w++) begin
                    len   = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 8)
                                                        : $urandom_range(16, 160);
                    close = (w != n_win - 1) || ($urandom_range(0, 5) != 0);
                    add_window(len, close, $urandom_range(0, 7) == 0);
                end
            end
            settle();
            phase++;
        end

        settle();
        if (n_errors == 0 && due_words.size() == 0)
            $display("pulse_peak_detector_tb: clean");
        else
            $display("pulse_peak_detector_tb: errors");
        $finish;
    end

endmodule
